// ----- rtl/core/swsc_pkg.sv -----
// Shared types, command codes and display/message tables for the stopwatch.
// No dependencies; the RTL files refer to it by scoped names, the testbench files import it.
`default_nettype none

package swsc_pkg;

  localparam int unsigned CountW = 10;

  typedef logic [CountW-1:0] count_t;
  typedef logic [3:0]        bcd_t;
  typedef logic [7:0]        byte_t;
  typedef logic [2:0]        msg_idx_t;

  localparam count_t LIMIT_RESET = count_t'(600);
  localparam count_t COUNT_MAX   = count_t'(1023);
  localparam byte_t  SEG_BLANK   = 8'hFF;

  // Received command characters
  localparam byte_t CMD_START_UC = 8'h49; // 'I'
  localparam byte_t CMD_START_LC = 8'h69; // 'i'
  localparam byte_t CMD_PAUSE_UC = 8'h50; // 'P'
  localparam byte_t CMD_PAUSE_LC = 8'h70; // 'p'
  localparam byte_t CMD_CLEAR_UC = 8'h43; // 'C'
  localparam byte_t CMD_CLEAR_LC = 8'h63; // 'c'

  // Word kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_RX    = 1'b1;
  localparam logic RES_FRAME  = 1'b0;
  localparam logic RES_CHAR   = 1'b1;

  // Slot 0 of a job is the frame, slots 1..MSG_LAST the message characters
  localparam msg_idx_t IDX_FRAME = msg_idx_t'(0);
  localparam msg_idx_t MSG_LAST  = msg_idx_t'(6);

  // Work handed from the counter to the output sequencer
  typedef struct packed {
    logic  emit;
    logic  msg;
    byte_t seg_tens;
    byte_t seg_units;
    byte_t seg_tenths;
  } job_t;

  // Common-anode pattern, bit 7 = segment a, bit 0 = decimal point
  function automatic byte_t seg_pattern(bcd_t digit);
    byte_t pat;
    unique case (digit)
      4'd0:    pat = 8'b0000_0010;
      4'd1:    pat = 8'b1001_1111;
      4'd2:    pat = 8'b0010_0101;
      4'd3:    pat = 8'b0000_1101;
      4'd4:    pat = 8'b1001_1001;
      4'd5:    pat = 8'b0100_1001;
      4'd6:    pat = 8'b0100_0001;
      4'd7:    pat = 8'b0001_1111;
      4'd8:    pat = 8'b0000_0001;
      4'd9:    pat = 8'b0000_1001;
      default: pat = SEG_BLANK;
    endcase
    return pat;
  endfunction

  // "Maximo", slot 1 is the first character
  function automatic byte_t msg_char(msg_idx_t idx);
    byte_t ch;
    unique case (idx)
      3'd1:    ch = 8'h4D;
      3'd2:    ch = 8'h61;
      3'd3:    ch = 8'h78;
      3'd4:    ch = 8'h69;
      3'd5:    ch = 8'h6D;
      3'd6:    ch = 8'h6F;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/swsc_if.sv -----
// Valid/ready channel interfaces for the stopwatch input and result words.
// Depends on swsc_pkg for payload types.
`default_nettype none

interface swsc_in_if;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  swsc_pkg::byte_t      rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface swsc_out_if;
  logic                 valid;
  logic                 ready;
  logic                 result_kind;
  swsc_pkg::byte_t      seg_tens;
  swsc_pkg::byte_t      seg_units;
  swsc_pkg::byte_t      seg_tenths;
  swsc_pkg::byte_t      tx_char;
  logic                 last;

  modport source (output valid, output result_kind, output seg_tens, output seg_units,
                  output seg_tenths, output tx_char, output last, input ready);
  modport sink   (input valid, input result_kind, input seg_tens, input seg_units,
                  input seg_tenths, input tx_char, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/swsc_counter.sv -----
// Command decode, tenths counter with parallel BCD digits and limit check.
// Depends on swsc_pkg.
`default_nettype none

module swsc_counter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               word_fire,
  input  logic               kind,
  input  swsc_pkg::byte_t    rx_byte,
  input  swsc_pkg::count_t   limit,
  output swsc_pkg::job_t     job
);

  swsc_pkg::count_t count_r, count_nxt, count_inc;
  swsc_pkg::bcd_t   d0_r, d1_r, d2_r, d0_nxt, d1_nxt, d2_nxt;
  swsc_pkg::bcd_t   d0_inc, d1_inc, d2_inc;
  logic             tick_en_r, tick_en_nxt;
  logic             run_r, run_nxt;
  logic             can_inc, hit_limit, tick_fire;

  // Saturating increment; BCD digits track the binary count, hundreds wraps
  always_comb begin
    can_inc   = (count_r != swsc_pkg::COUNT_MAX);
    count_inc = can_inc ? count_r + swsc_pkg::count_t'(1) : count_r;
    d0_inc    = d0_r;
    d1_inc    = d1_r;
    d2_inc    = d2_r;
    if (can_inc) begin
      if (d0_r == 4'd9) begin
        d0_inc = 4'd0;
        if (d1_r == 4'd9) begin
          d1_inc = 4'd0;
          d2_inc = (d2_r == 4'd9) ? 4'd0 : d2_r + 4'd1;
        end else begin
          d1_inc = d1_r + 4'd1;
        end
      end else begin
        d0_inc = d0_r + 4'd1;
      end
    end
    hit_limit = (count_inc >= limit);
  end

  assign tick_fire = word_fire && (kind == swsc_pkg::KIND_TICK) && tick_en_r;

  always_comb begin
    count_nxt   = count_r;
    d0_nxt      = d0_r;
    d1_nxt      = d1_r;
    d2_nxt      = d2_r;
    tick_en_nxt = tick_en_r;
    run_nxt     = run_r;
    if (word_fire && (kind == swsc_pkg::KIND_RX)) begin
      priority if (rx_byte == swsc_pkg::CMD_START_UC || rx_byte == swsc_pkg::CMD_START_LC) begin
        tick_en_nxt = 1'b1;
        run_nxt     = 1'b1;
      end else if (rx_byte == swsc_pkg::CMD_PAUSE_UC ||
                   rx_byte == swsc_pkg::CMD_PAUSE_LC) begin
        tick_en_nxt = 1'b0;
        run_nxt     = 1'b0;
      end else if ((rx_byte == swsc_pkg::CMD_CLEAR_UC ||
                    rx_byte == swsc_pkg::CMD_CLEAR_LC) && !run_r) begin
        tick_en_nxt = 1'b1;
        count_nxt   = '0;
        d0_nxt      = '0;
        d1_nxt      = '0;
        d2_nxt      = '0;
      end else begin
        // drop unknown bytes
      end
    end else if (tick_fire) begin
      count_nxt = count_inc;
      d0_nxt    = d0_inc;
      d1_nxt    = d1_inc;
      d2_nxt    = d2_inc;
      if (hit_limit) begin
        tick_en_nxt = 1'b0;
        run_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      d0_r      <= '0;
      d1_r      <= '0;
      d2_r      <= '0;
      tick_en_r <= 1'b0;
      run_r     <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      d0_r      <= d0_nxt;
      d1_r      <= d1_nxt;
      d2_r      <= d2_nxt;
      tick_en_r <= tick_en_nxt;
      run_r     <= run_nxt;
    end
  end

  // Frame shows the count before the increment
  always_comb begin
    job.emit       = tick_fire;
    job.msg        = hit_limit;
    job.seg_tens   = swsc_pkg::seg_pattern(d2_r);
    job.seg_units  = swsc_pkg::seg_pattern(d1_r);
    job.seg_tenths = swsc_pkg::seg_pattern(d0_r);
  end

endmodule

`default_nettype wire

// ----- rtl/core/stopwatch_with_serial_commands.sv -----
// Top level of the tenths-of-second stopwatch: count limit register,
// output job register and result sequencer. Depends on swsc_pkg, swsc_if, swsc_counter.
//
//   Channel   Dir  Word                                   Handshake
//   in_ch     in   kind, rx_byte (tick or command byte)  valid/ready
//   out_ch    out  result_kind, seg_*, tx_char, last      valid/ready
//   cfg_*     in   cfg_wdata (10 bits)                   cfg_we, no ready
//
// A command byte or a disabled tick is absorbed and gives no word.
// An enabled tick gives a frame word in the cycle after acceptance; a tick that
// reaches the limit gives a frame plus six message words.
// The single job register sets the rate: a new word is taken each cycle while
// the job register is empty or its final word leaves in that cycle.
// Reset (rst_n low, synchronous) clears the count, flags and job register and
// loads the limit with 600. Output stalls hold the job register and the input.
`default_nettype none

module stopwatch_with_serial_commands (
  input  logic               clk,
  input  logic               rst_n,
  swsc_in_if.sink            in_ch,
  swsc_out_if.source         out_ch,
  input  logic               cfg_we,
  input  swsc_pkg::count_t   cfg_wdata
);

  swsc_pkg::count_t   limit_r;
  swsc_pkg::job_t     job;

  // Job register: one frame plus optional message, walked by idx_r
  logic               job_valid_r, job_valid_nxt;
  logic               msg_r, msg_nxt;
  swsc_pkg::msg_idx_t idx_r, idx_nxt;
  swsc_pkg::byte_t    seg_tens_r, seg_units_r, seg_tenths_r;

  logic               last_now, out_fire, in_ready, in_fire;

  // Hold the limit; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= swsc_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // Final word of the current job: the frame alone, or the last character
  assign last_now = ((idx_r == swsc_pkg::IDX_FRAME) && !msg_r) || (idx_r == swsc_pkg::MSG_LAST);
  assign out_fire = job_valid_r && out_ch.ready;
  // Take a new word when the job register is free or drains this cycle
  assign in_ready = !job_valid_r || (out_ch.ready && last_now);
  assign in_fire  = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  swsc_counter u_counter (
    .clk       (clk),
    .rst_n     (rst_n),
    .word_fire (in_fire),
    .kind      (in_ch.kind),
    .rx_byte   (in_ch.rx_byte),
    .limit     (limit_r),
    .job       (job)
  );

  always_comb begin
    job_valid_nxt = job_valid_r;
    msg_nxt       = msg_r;
    idx_nxt       = idx_r;
    if (in_fire && job.emit) begin
      // Load a fresh job; the previous one has drained or was empty
      job_valid_nxt = 1'b1;
      msg_nxt       = job.msg;
      idx_nxt       = swsc_pkg::IDX_FRAME;
    end else if (out_fire) begin
      if (last_now) begin
        job_valid_nxt = 1'b0;
        idx_nxt       = swsc_pkg::IDX_FRAME;
      end else begin
        // Advance to the next message character
        idx_nxt = idx_r + swsc_pkg::msg_idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      msg_r       <= 1'b0;
      idx_r       <= swsc_pkg::IDX_FRAME;
    end else begin
      job_valid_r <= job_valid_nxt;
      msg_r       <= msg_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // Segment payload needs no reset
  always_ff @(posedge clk) begin
    if (in_fire && job.emit) begin
      seg_tens_r   <= job.seg_tens;
      seg_units_r  <= job.seg_units;
      seg_tenths_r <= job.seg_tenths;
    end
  end

  // Frame slot shows the segments, message slots blank them and carry a character
  always_comb begin
    out_ch.valid = job_valid_r;
    out_ch.last  = last_now;
    if (idx_r == swsc_pkg::IDX_FRAME) begin
      out_ch.result_kind = swsc_pkg::RES_FRAME;
      out_ch.seg_tens    = seg_tens_r;
      out_ch.seg_units   = seg_units_r;
      out_ch.seg_tenths  = seg_tenths_r;
    end else begin
      out_ch.result_kind = swsc_pkg::RES_CHAR;
      out_ch.seg_tens    = swsc_pkg::SEG_BLANK;
      out_ch.seg_units   = swsc_pkg::SEG_BLANK;
      out_ch.seg_tenths  = swsc_pkg::SEG_BLANK;
    end
    out_ch.tx_char = swsc_pkg::msg_char(idx_r);
  end

`ifndef SYNTHESIS
  // Message slots are reached only by jobs that carry the message
  a_idx_needs_msg: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != swsc_pkg::IDX_FRAME) |-> (msg_r && job_valid_r))
    else $error("message slot without message job");

  // A non-final word that leaves is followed by the next slot of the same job
  a_idx_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !last_now) |=>
      (job_valid_r && idx_r == $past(idx_r) + swsc_pkg::msg_idx_t'(1)))
    else $error("sequencer did not advance");

  // The slot index never passes the last message character
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r |-> (idx_r <= swsc_pkg::MSG_LAST))
    else $error("slot index out of range");
`endif

endmodule

`default_nettype wire

// ----- tb/stopwatch_word_checker.sv -----
// Result-word checker for the stopwatch: keeps its own count, flags and limit,
// predicts the words each accepted input word causes and compares them in order.
// Depends on swsc_pkg and the channel interfaces in swsc_if.
module stopwatch_word_checker
  import swsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  swsc_in_if       in_ch,
  swsc_out_if      out_ch,
  input  logic     cfg_we,
  input  count_t   cfg_wdata,
  output int       mismatches,
  output int       words_due
);

  typedef struct packed {
    logic  result_kind;
    byte_t seg_tens;
    byte_t seg_units;
    byte_t seg_tenths;
    byte_t tx_char;
    logic  last;
  } result_word_t;

  // Active-low glyphs, segment a in bit 7, decimal point in bit 0
  localparam byte_t DIGIT_GLYPH [10] = '{
    8'h02, 8'h9F, 8'h25, 8'h0D, 8'h99, 8'h49, 8'h41, 8'h1F, 8'h01, 8'h09
  };
  // "Maximo"
  localparam byte_t SIGN_OFF [6] = '{8'h4D, 8'h61, 8'h78, 8'h69, 8'h6D, 8'h6F};

  count_t       tenths;
  count_t       count_limit;
  logic         ticking;
  logic         active;
  result_word_t due_words [$];

  // Advance the stopwatch by one input word and queue the words it must emit.
  task automatic advance_stopwatch(input logic kind, input byte_t rx);
    result_word_t frame;
    result_word_t ch;
    int           i;
    if (kind == KIND_RX) begin
      case (rx)
        CMD_START_UC, CMD_START_LC: begin
          ticking = 1'b1;
          active  = 1'b1;
        end
        CMD_PAUSE_UC, CMD_PAUSE_LC: begin
          ticking = 1'b0;
          active  = 1'b0;
        end
        CMD_CLEAR_UC, CMD_CLEAR_LC: begin
          if (!active) begin
            ticking = 1'b1;
            tenths  = '0;
          end
        end
        default: ;
      endcase
    end else if (ticking) begin
      frame.result_kind = RES_FRAME;
      frame.seg_tens    = DIGIT_GLYPH[(int'(tenths) / 100) % 10];
      frame.seg_units   = DIGIT_GLYPH[(int'(tenths) / 10) % 10];
      frame.seg_tenths  = DIGIT_GLYPH[int'(tenths) % 10];
      frame.tx_char     = 8'h00;
      frame.last        = 1'b0;
      if (tenths != COUNT_MAX) tenths = tenths + 1'b1;
      if (tenths >= count_limit) begin
        ticking = 1'b0;
        active  = 1'b0;
        due_words.push_back(frame);
        for (i = 0; i < 6; i++) begin
          ch.result_kind = RES_CHAR;
          ch.seg_tens    = SEG_BLANK;
          ch.seg_units   = SEG_BLANK;
          ch.seg_tenths  = SEG_BLANK;
          ch.tx_char     = SIGN_OFF[i];
          ch.last        = (i == 5);
          due_words.push_back(ch);
        end
      end else begin
        frame.last = 1'b1;
        due_words.push_back(frame);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    result_word_t got;
    result_word_t want;
    if (!rst_n) begin
      tenths      = '0;
      count_limit = LIMIT_RESET;
      ticking     = 1'b0;
      active      = 1'b0;
      mismatches  = 0;
      due_words.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.result_kind = out_ch.result_kind;
        got.seg_tens    = out_ch.seg_tens;
        got.seg_units   = out_ch.seg_units;
        got.seg_tenths  = out_ch.seg_tenths;
        got.tx_char     = out_ch.tx_char;
        got.last        = out_ch.last;
        if (due_words.size() == 0) begin
          $display("%0t: expected no word, got kind=%0d seg=%h_%h_%h tx=%h last=%0d",
                   $time, got.result_kind, got.seg_tens, got.seg_units,
                   got.seg_tenths, got.tx_char, got.last);
          mismatches++;
        end else begin
          want = due_words.pop_front();
          if (got.result_kind !== want.result_kind || got.seg_tens !== want.seg_tens ||
              got.seg_units !== want.seg_units || got.seg_tenths !== want.seg_tenths ||
              got.tx_char !== want.tx_char || got.last !== want.last) begin
            $display({"%0t: expected kind=%0d seg=%h_%h_%h tx=%h last=%0d,",
                      " got kind=%0d seg=%h_%h_%h tx=%h last=%0d"},
                     $time, want.result_kind, want.seg_tens, want.seg_units,
                     want.seg_tenths, want.tx_char, want.last, got.result_kind,
                     got.seg_tens, got.seg_units, got.seg_tenths, got.tx_char, got.last);
            mismatches++;
          end
        end
      end
      if (cfg_we) count_limit = cfg_wdata;
      if (in_ch.valid && in_ch.ready) advance_stopwatch(in_ch.kind, in_ch.rx_byte);
    end
    words_due = due_words.size();
  end

endmodule

// ----- tb/tb_stopwatch_with_serial_commands.sv -----
// Testbench top for the stopwatch: clock, reset, stimulus on the tick/command
// channel, random back-pressure on the result channel, watchdog and verdict.
// Depends on swsc_pkg, swsc_if, the RTL top and stopwatch_word_checker.
module tb_stopwatch_with_serial_commands;
  import swsc_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;    // command words leave nothing behind
  localparam int unsigned CHOKE_CYCLES  = 80;   // one long receiver hold-off
  localparam int unsigned STALL_LIMIT   = 2000; // cycles with no word moving
  localparam int unsigned PHASE_ITEMS   = 50;

  logic   clk;
  logic   rst_n;
  logic   cfg_we;
  count_t cfg_wdata;
  int     mismatches;
  int     words_due;

  // Shared knobs between the stimulus and the receiver process
  bit calm;        // no gaps on either side
  bit rush;        // sender only: no gaps
  bit choke_req;   // ask the receiver for its long hold-off
  bit choke_done;

  swsc_in_if  in_ch ();
  swsc_out_if out_ch ();

  stopwatch_with_serial_commands dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  stopwatch_word_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .words_due  (words_due)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Gap length: mostly a few cycles, now and then a long one.
  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned sender_gap();
    if (calm || rush) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return idle_span();
  endfunction

  // Pick a command byte: mostly real commands in either case, some noise.
  function automatic byte_t pick_command();
    int unsigned r;
    bit          lower;
    r     = $urandom_range(0, 99);
    lower = $urandom_range(0, 1);
    if (r < 40) return lower ? CMD_START_LC : CMD_START_UC;
    if (r < 55) return lower ? CMD_PAUSE_LC : CMD_PAUSE_UC;
    if (r < 80) return lower ? CMD_CLEAR_LC : CMD_CLEAR_UC;
    return byte_t'($urandom_range(0, 255));
  endfunction

  // Offer one word after a random gap and hold it until the block takes it.
  // Valid stays high across back-to-back words so it is never dropped and
  // raised in the same step.
  task automatic send_word(input logic kind, input byte_t payload);
    int unsigned gap;
    gap = sender_gap();
    if (gap != 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kind;
    in_ch.rx_byte <= payload;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_tick();
    send_word(KIND_TICK, byte_t'($urandom_range(0, 255)));
  endtask

  // Drop valid, let every predicted word arrive, then give trailing command
  // words time to clear the block before anything else happens.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (words_due == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the count limit; call only with the block idle.
  task automatic write_limit(input count_t value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random traffic: mostly ticks so the count keeps moving, commands between.
  task automatic random_words(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 99) < 62) send_tick();
      else send_word(KIND_RX, pick_command());
    end
  endtask

  // Receiver: ready most cycles, random stalls, one long hold-off on request.
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (choke_req && !choke_done) begin
        out_ch.ready <= 1'b0;
        repeat (CHOKE_CYCLES) @(negedge clk);
        choke_done = 1'b1;
        out_ch.ready <= 1'b1;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        stall = idle_span();
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no word has moved for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int phase;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.kind    = KIND_TICK;
    in_ch.rx_byte = 8'h00;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    calm          = 1'b0;
    rush          = 1'b0;
    choke_req     = 1'b0;
    choke_done    = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: disabled tick and junk bytes are absorbed silently
    send_tick();
    send_word(KIND_RX, 8'h00);
    send_word(KIND_RX, 8'hFF);
    // Clear while inactive enables ticking without marking the watch active
    send_word(KIND_RX, CMD_CLEAR_UC);
    send_tick();
    send_tick();
    // Start, pause (tick dropped), restart
    send_word(KIND_RX, CMD_START_UC);
    send_tick();
    send_word(KIND_RX, CMD_PAUSE_LC);
    send_tick();
    send_word(KIND_RX, CMD_START_LC);
    send_tick();
    // Clear while running is ignored
    send_word(KIND_RX, CMD_CLEAR_LC);
    send_tick();
    send_word(KIND_RX, CMD_PAUSE_UC);
    send_word(KIND_RX, CMD_CLEAR_LC);
    send_tick();
    drain();

    // Small limit: reach it, tick after the stop is dropped, resume stops again
    write_limit(count_t'(3));
    send_word(KIND_RX, CMD_START_UC);
    send_tick();
    send_tick();
    send_tick();
    send_tick();
    send_word(KIND_RX, CMD_START_LC);
    send_tick();
    drain();

    // Limit of zero: the first enabled tick stops at once
    write_limit(count_t'(0));
    send_word(KIND_RX, CMD_CLEAR_UC);
    send_tick();
    drain();

    // Random phases, each with its own limit
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_limit(count_t'(1));
        1: write_limit(count_t'($urandom_range(5, 30)));
        2: write_limit(count_t'(999));
        3: write_limit(count_t'($urandom_range(2, 60)));
        default: write_limit(count_t'($urandom_range(20, 40)));
      endcase
      calm = (phase == 3);
      if (phase == 4) begin
        // Fill the block: hold the receiver off while ticks keep coming
        send_word(KIND_RX, CMD_PAUSE_LC);
        send_word(KIND_RX, CMD_CLEAR_UC);
        send_word(KIND_RX, CMD_START_UC);
        choke_req = 1'b1;
        rush      = 1'b1;
        repeat (30) send_tick();
        rush      = 1'b0;
        random_words(PHASE_ITEMS - 33);
      end else begin
        random_words(PHASE_ITEMS);
      end
      drain();
    end
    calm = 1'b0;

    if (mismatches == 0 && words_due == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
